FILE: rtl/clex_pkg.sv
// ----------------------------------------------------------------------------
// clex_pkg
// Types, constants and character class helpers for the config text lexer.
// ----------------------------------------------------------------------------
package clex_pkg;

  localparam int NUMBER_BITS = 31;
  localparam int SUM_BITS    = NUMBER_BITS + 4;
  localparam int TDATA_BITS  = 10 + NUMBER_BITS;
  localparam int TDATA_W     = ((TDATA_BITS + 7) / 8) * 8;
  localparam int TDATA_PAD   = TDATA_W - TDATA_BITS;

  // output queue, power of two depth
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WORD = 2'd1,
    PH_NUM  = 2'd2,
    PH_ERR  = 2'd3
  } clex_phase_e;

  typedef enum logic [3:0] {
    KIND_WORD     = 4'd0,
    KIND_NUM      = 4'd1,
    KIND_COLON    = 4'd2,
    KIND_DOT      = 4'd3,
    KIND_HYPHEN   = 4'd4,
    KIND_SPACE    = 4'd5,
    KIND_BREAK    = 4'd6,
    KIND_INVALID  = 4'd7,
    KIND_OVERFLOW = 4'd8
  } clex_kind_e;

  typedef struct packed {
    clex_kind_e               kind;
    logic [7:0]               word_char;
    logic                     word_first;
    logic                     word_last;
    logic [NUMBER_BITS-1:0]   number_value;
    logic                     run_last;
  } clex_res_t;

  // results produced by one character, res0 first
  typedef struct packed {
    logic [1:0] cnt;
    clex_res_t  res0;
    clex_res_t  res1;
  } clex_push_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
  endfunction

  function automatic logic is_dig(logic [7:0] c);
    return (c inside {[8'h30:8'h39]});
  endfunction

  function automatic logic starts_word(logic [7:0] c);
    return is_alpha(c) || (c == CH_UNDER);
  endfunction

  function automatic logic inside_word(logic [7:0] c);
    return is_alpha(c) || is_dig(c) || (c == CH_UNDER);
  endfunction

  function automatic clex_kind_e punct_kind(logic [7:0] c);
    clex_kind_e k;
    case (c)
      CH_COLON:     k = KIND_COLON;
      CH_DOT:       k = KIND_DOT;
      CH_HYPHEN:    k = KIND_HYPHEN;
      CH_SPACE:     k = KIND_SPACE;
      CH_CR, CH_LF: k = KIND_BREAK;
      default:      k = KIND_INVALID;
    endcase
    return k;
  endfunction

  function automatic clex_res_t mk_res(clex_kind_e k, logic [7:0] wc, logic wf, logic wl,
                                       logic [NUMBER_BITS-1:0] num);
    clex_res_t r;
    r.kind         = k;
    r.word_char    = wc;
    r.word_first   = wf;
    r.word_last    = wl;
    r.number_value = num;
    r.run_last     = 1'b0;
    return r;
  endfunction

endpackage

FILE: rtl/config_text_lexer_top.sv
// ----------------------------------------------------------------------------
// config_text_lexer_top
// Streaming lexer for configuration text, one ASCII character per transaction.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                                     tlast         tuser
//  s_axis   in   [7:0] ch                                  stream_last   -
//  m_axis   out  [7:0] word_char [8] word_first            run_last      [3:0] kind
//                [9] word_last [40:10] number_value
//
// a character enters the input register and is lexed from it into up to two
// results; a character with two results holds the output port for both, so the
// single output port sets the rate: one result per cycle while the sink is ready
// reset clears the lexer phase and the result queue; no clearing pass
// the input register holds while the four-entry result queue has fewer than
// two free slots
// ----------------------------------------------------------------------------
module config_text_lexer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,   // [7:0] ch
  input  logic                          s_axis_tlast_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [7:0] word_char, [8] word_first, [9] word_last, [40:10] number_value
  output logic [clex_pkg::TDATA_W-1:0]  m_axis_tdata_o,
  output logic                          m_axis_tlast_o,
  output logic [3:0]                    m_axis_tuser_o    // [3:0] kind
);

  logic                  in_valid_q, in_valid_d;
  logic [7:0]            in_ch_q;
  logic                  in_last_q;
  logic                  lex_fire;
  logic                  space;
  clex_pkg::clex_push_t  push;
  clex_pkg::clex_res_t   res;

  assign lex_fire        = in_valid_q && space;
  assign s_axis_tready_o = !in_valid_q || lex_fire;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_d = 1'b1;
    end else if (lex_fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_ch_q   <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  clex_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (lex_fire),
    .ch_i   (in_ch_q),
    .last_i (in_last_q),
    .push_o (push)
  );

  clex_out_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .pop_ready_i (m_axis_tready_i),
    .valid_o     (m_axis_tvalid_o),
    .res_o       (res),
    .space_o     (space)
  );

  assign m_axis_tdata_o = {{clex_pkg::TDATA_PAD{1'b0}}, res.number_value, res.word_last,
                           res.word_first, res.word_char};
  assign m_axis_tlast_o = res.run_last;
  assign m_axis_tuser_o = res.kind;

endmodule

FILE: rtl/clex_core.sv
// ----------------------------------------------------------------------------
// clex_core
// Lexer state and next-state logic; lexes one registered character per cycle
// into up to two results while fire_i is high.
// ----------------------------------------------------------------------------
module clex_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          ch_i,
  input  logic                last_i,
  output clex_pkg::clex_push_t push_o
);

  clex_pkg::clex_phase_e              phase_q, phase_d;
  logic [7:0]                         held_char_q, held_char_d;
  logic                               held_first_q, held_first_d;
  logic [clex_pkg::NUMBER_BITS-1:0]   accum_q, accum_d;

  clex_pkg::clex_res_t                res [2];
  logic [1:0]                         cnt;
  logic                               fresh;
  logic [3:0]                         dig;
  logic [clex_pkg::SUM_BITS-1:0]      sum;
  logic                               ovf;
  logic [clex_pkg::NUMBER_BITS-1:0]   dig_w;
  clex_pkg::clex_kind_e               pk;

  assign dig   = ch_i[3:0];
  assign dig_w = clex_pkg::NUMBER_BITS'(dig);
  // accum*10 + digit
  assign sum   = (clex_pkg::SUM_BITS'(accum_q) << 3) + (clex_pkg::SUM_BITS'(accum_q) << 1)
               + clex_pkg::SUM_BITS'(dig);
  assign ovf   = (sum[clex_pkg::SUM_BITS-1:clex_pkg::NUMBER_BITS] != '0);
  assign pk    = clex_pkg::punct_kind(ch_i);

  always_comb begin
    phase_d      = phase_q;
    held_char_d  = held_char_q;
    held_first_d = held_first_q;
    accum_d      = accum_q;
    res[0]       = '0;
    res[1]       = '0;
    cnt          = 2'd0;
    fresh        = 1'b1;
    if (fire_i) begin
      case (phase_q)
        clex_pkg::PH_ERR: begin
          if (last_i) phase_d = clex_pkg::PH_IDLE;
          fresh = 1'b0;
        end
        clex_pkg::PH_WORD: begin
          if (clex_pkg::inside_word(ch_i)) begin
            res[cnt[0]] = clex_pkg::mk_res(clex_pkg::KIND_WORD, held_char_q, held_first_q,
                                           1'b0, '0);
            cnt = cnt + 2'd1;
            held_char_d  = ch_i;
            held_first_d = 1'b0;
            if (last_i) begin
              res[cnt[0]] = clex_pkg::mk_res(clex_pkg::KIND_WORD, ch_i, 1'b0, 1'b1, '0);
              cnt = cnt + 2'd1;
              phase_d = clex_pkg::PH_IDLE;
            end
            fresh = 1'b0;
          end else begin
            res[cnt[0]] = clex_pkg::mk_res(clex_pkg::KIND_WORD, held_char_q, held_first_q,
                                           1'b1, '0);
            cnt = cnt + 2'd1;
            phase_d = clex_pkg::PH_IDLE;
          end
        end
        clex_pkg::PH_NUM: begin
          if (clex_pkg::is_dig(ch_i)) begin
            if (ovf) begin
              res[cnt[0]] = clex_pkg::mk_res(clex_pkg::KIND_OVERFLOW, 8'h00, 1'b0, 1'b0, '0);
              cnt = cnt + 2'd1;
              accum_d = '0;
              phase_d = last_i ? clex_pkg::PH_IDLE : clex_pkg::PH_ERR;
            end else begin
              accum_d = sum[clex_pkg::NUMBER_BITS-1:0];
              if (last_i) begin
                res[cnt[0]] = clex_pkg::mk_res(clex_pkg::KIND_NUM, 8'h00, 1'b0, 1'b0,
                                               sum[clex_pkg::NUMBER_BITS-1:0]);
                cnt = cnt + 2'd1;
                accum_d = '0;
                phase_d = clex_pkg::PH_IDLE;
              end
            end
            fresh = 1'b0;
          end else begin
            res[cnt[0]] = clex_pkg::mk_res(clex_pkg::KIND_NUM, 8'h00, 1'b0, 1'b0, accum_q);
            cnt = cnt + 2'd1;
            accum_d = '0;
            phase_d = clex_pkg::PH_IDLE;
          end
        end
        default: ;
      endcase

      if (fresh) begin
        if (clex_pkg::starts_word(ch_i)) begin
          if (last_i) begin
            res[cnt[0]] = clex_pkg::mk_res(clex_pkg::KIND_WORD, ch_i, 1'b1, 1'b1, '0);
            cnt = cnt + 2'd1;
          end else begin
            held_char_d  = ch_i;
            held_first_d = 1'b1;
            phase_d      = clex_pkg::PH_WORD;
          end
        end else if (clex_pkg::is_dig(ch_i)) begin
          if (last_i) begin
            res[cnt[0]] = clex_pkg::mk_res(clex_pkg::KIND_NUM, 8'h00, 1'b0, 1'b0, dig_w);
            cnt = cnt + 2'd1;
            accum_d = '0;
          end else begin
            accum_d = dig_w;
            phase_d = clex_pkg::PH_NUM;
          end
        end else begin
          res[cnt[0]] = clex_pkg::mk_res(pk, 8'h00, 1'b0, 1'b0, '0);
          cnt = cnt + 2'd1;
          if ((pk == clex_pkg::KIND_INVALID) && !last_i) phase_d = clex_pkg::PH_ERR;
        end
      end
    end

    // mark the final result of this character
    if (cnt == 2'd2) begin
      res[1].run_last = 1'b1;
    end else if (cnt == 2'd1) begin
      res[0].run_last = 1'b1;
    end

    push_o.cnt  = cnt;
    push_o.res0 = res[0];
    push_o.res1 = res[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= clex_pkg::PH_IDLE;
      held_char_q  <= 8'h00;
      held_first_q <= 1'b0;
      accum_q      <= '0;
    end else begin
      phase_q      <= phase_d;
      held_char_q  <= held_char_d;
      held_first_q <= held_first_d;
      accum_q      <= accum_d;
    end
  end

endmodule

FILE: rtl/clex_out_fifo.sv
// ----------------------------------------------------------------------------
// clex_out_fifo
// Result queue; takes up to two results per cycle, pops one per ready cycle.
// ----------------------------------------------------------------------------
module clex_out_fifo (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  clex_pkg::clex_push_t                push_i,
  input  logic                                pop_ready_i,
  output logic                                valid_o,
  output clex_pkg::clex_res_t                 res_o,
  output logic                                space_o
);

  clex_pkg::clex_res_t              mem_q [clex_pkg::OQ_DEPTH];
  logic [clex_pkg::OQ_PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [clex_pkg::OQ_PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [clex_pkg::OQ_CNT_W-1:0]    count_q, count_d;
  logic                             pop;

  assign valid_o = (count_q != '0);
  assign res_o   = mem_q[rd_ptr_q];
  assign pop     = valid_o && pop_ready_i;
  // room for the worst case of two results
  assign space_o = (count_q <= clex_pkg::OQ_CNT_W'(clex_pkg::OQ_DEPTH - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + clex_pkg::OQ_PTR_W'(push_i.cnt);
    rd_ptr_d = rd_ptr_q + clex_pkg::OQ_PTR_W'(pop);
    count_d  = count_q + clex_pkg::OQ_CNT_W'(push_i.cnt) - clex_pkg::OQ_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wr_ptr_q] <= push_i.res0;
    if (push_i.cnt == 2'd2) mem_q[wr_ptr_q + clex_pkg::OQ_PTR_W'(1)] <= push_i.res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

FILE: rtl/clex_checker.sv
// ----------------------------------------------------------------------------
// clex_checker
// Port-level checks on the lexer's result stream.
// ----------------------------------------------------------------------------
module clex_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [clex_pkg::TDATA_W-1:0]  m_axis_tdata_o,
  input logic                          m_axis_tlast_o,
  input logic [3:0]                    m_axis_tuser_o
);

  // a stalled result transaction holds its contents
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

  // no result is offered in the cycle after a reset cycle
  assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("result valid after reset");

  // word fields are zero unless the result is a word character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != clex_pkg::KIND_WORD) |->
      (m_axis_tdata_o[9:0] == 10'd0))
    else $error("word fields set on non-word result");

  // number value is zero unless the result is a number
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != clex_pkg::KIND_NUM) |->
      (m_axis_tdata_o[clex_pkg::TDATA_W-1:10] == '0))
    else $error("number value set on non-number result");

endmodule

bind config_text_lexer_top clex_checker u_clex_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
